/* rtl/becke_partition_weight_top_macros.svh */
// Assertion macros used by the partition weight controller.
// Each macro expands to one labeled concurrent assertion on clk and arst_n.
`ifndef BECKE_PARTITION_WEIGHT_TOP_MACROS_SVH
`define BECKE_PARTITION_WEIGHT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPW_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPW_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bpw_pkg.sv */
// Shared types, widths and command codes for the partition weight block.
// No dependencies; used by bpw_ctrl, bpw_dp and the top level.
package bpw_pkg;

	localparam int DEFAULT_MAX_ATOMS = 16;
	localparam int SLOT_W   = 4;
	localparam int COORD_W  = 32;
	localparam int WEIGHT_W = 48;
	localparam int CNT_W    = 5;

	localparam int DIST_W   = 33;
	localparam int ACC_W    = 66;
	localparam int REM_W    = 36;
	localparam int MUL_W    = 33;
	localparam int PROD_W   = 66;
	localparam int FRAC     = 30;
	localparam int Q_W      = 31;
	localparam int SUM_W    = 36;
	localparam int DIV_W    = 37;
	localparam int WB_W     = 55;
	localparam int FULL_W   = 79;

	localparam int SQRT_STEPS = 33;
	localparam int DIV_STEPS  = 31;

	localparam logic [Q_W-1:0] Q_ONE   = 31'h4000_0000;
	localparam logic [31:0]    Q_THREE = 32'hC000_0000;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_POINT = 1'b1;

	localparam logic [3:0] MUL_NONE = 4'd0;
	localparam logic [3:0] MUL_SQX  = 4'd1;
	localparam logic [3:0] MUL_SQY  = 4'd2;
	localparam logic [3:0] MUL_SQZ  = 4'd3;
	localparam logic [3:0] MUL_M2   = 4'd4;
	localparam logic [3:0] MUL_S    = 4'd5;
	localparam logic [3:0] MUL_CI   = 4'd6;
	localparam logic [3:0] MUL_CJ   = 4'd7;
	localparam logic [3:0] MUL_WB   = 4'd8;
	localparam logic [3:0] MUL_WA   = 4'd9;

	localparam logic [1:0] CW_INIT = 2'd0;
	localparam logic [1:0] CW_I    = 2'd1;
	localparam logic [1:0] CW_J    = 2'd2;

	typedef struct packed {
		logic                       opcode;
		logic [SLOT_W-1:0]          atom_index;
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
		logic signed [COORD_W-1:0]  pos_z;
		logic [WEIGHT_W-1:0]        raw_weight;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  abs_x;
		logic signed [COORD_W-1:0]  abs_y;
		logic signed [COORD_W-1:0]  abs_z;
		logic [WEIGHT_W-1:0]        part_weight;
		logic                       error_flag;
	} out_t;

	typedef struct packed {
		logic       in_ld;
		logic       tbl_wr;
		logic       tbl_rd;
		logic       own_sel;
		logic       abs_ld;
		logic       ai_ld;
		logic       diff_pt;
		logic       diff_pr;
		logic [3:0] mul_sel;
		logic       acc_clr;
		logic       acc_add;
		logic       sqrt_ld;
		logic       sqrt_step;
		logic       dist_wr;
		logic       dist_rd;
		logic       di_ld;
		logic       r_ld;
		logic       div_ld_mu;
		logic       div_ld_q;
		logic       div_step;
		logic       mu_ld;
		logic       m2_ld;
		logic       s_ld;
		logic       cell_wr;
		logic [1:0] cell_src;
		logic       cell_rd;
		logic       ci_ld;
		logic       ci_upd;
		logic       err_clr;
		logic       err_set;
		logic       sum_clr;
		logic       sum_add;
		logic       q_ld;
		logic       wb_ld;
		logic       wt_ld;
		logic       res_ld;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic             owner_act;
		logic             r_zero;
		logic             ge;
		logic             fail;
	} sts_t;

endpackage

/* rtl/bpw_dp.sv */
// Datapath: atom tables, distance and cell memories, shared multiplier,
// square root and divider units, result register. Depends on bpw_pkg.
module bpw_dp #(
	parameter int MAX_ATOMS = bpw_pkg::DEFAULT_MAX_ATOMS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bpw_pkg::in_t                      in_data,
	input  logic                              cfg_wr,
	input  logic [bpw_pkg::CNT_W-1:0]         cfg_data,
	input  bpw_pkg::cmd_t                     cmd,
	input  logic [$clog2(MAX_ATOMS)-1:0]      addr,
	output bpw_pkg::sts_t                     sts,
	output bpw_pkg::out_t                     out_data
);
	import bpw_pkg::*;

	localparam int AW = $clog2(MAX_ATOMS);

	logic signed [COORD_W-1:0] mem_x [MAX_ATOMS];
	logic signed [COORD_W-1:0] mem_y [MAX_ATOMS];
	logic signed [COORD_W-1:0] mem_z [MAX_ATOMS];
	logic [MAX_ATOMS-1:0]      vld_q;
	logic [DIST_W-1:0]         dist_mem [MAX_ATOMS];
	logic [Q_W-1:0]            cell_mem [MAX_ATOMS];

	in_t                       in_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [COORD_W-1:0] rd_x_q, rd_y_q, rd_z_q;
	logic signed [COORD_W-1:0] ax_q, ay_q, az_q;
	logic signed [COORD_W-1:0] aix_q, aiy_q, aiz_q;
	logic [COORD_W-1:0]        dx_q, dy_q, dz_q;
	logic [PROD_W-1:0]         prod_q;
	logic [ACC_W-1:0]          acc_q;
	logic [ACC_W-1:0]          rad_q;
	logic [REM_W-1:0]          srem_q;
	logic [DIST_W-1:0]         root_q;
	logic [DIST_W-1:0]         dr_q, di_q, r_q, mag_q;
	logic                      neg_q, ge_q;
	logic [DIV_W-1:0]          drem_q;
	logic [SUM_W-1:0]          den_q;
	logic [Q_W-1:0]            quo_q;
	logic [Q_W-1:0]            mu_q, m2_q, fm_q, fp_q, ci_q, cr_q, q_q;
	logic                      err_q;
	logic [SUM_W-1:0]          sum_q;
	logic [WB_W-1:0]           wb_q;
	logic [WEIGHT_W-1:0]       w_q;
	out_t                      out_q;

	logic [AW-1:0]             wa, own_a, ra;
	logic                      ld_ok, own_ok, rd_ok;
	logic [CNT_W-1:0]          n;
	logic                      owner_act, fail;
	logic [MUL_W-1:0]          op_a, op_b;
	logic [PROD_W-1:0]         prod_c;
	logic [REM_W-1:0]          srem_n, strial;
	logic [DIST_W:0]           di_m_dr, dr_m_di;
	logic [DIST_W-1:0]         mag_c;
	logic [DIV_W-1:0]          drem_n;
	logic                      dge;
	logic [Q_W-1:0]            smag;
	logic [Q_W:0]              fm_t;
	logic [Q_W-1:0]            fm_c;
	logic [FULL_W-1:0]         full_c;
	logic [Q_W-1:0]            cell_wd;

	function automatic logic signed [COORD_W-1:0] sat_add(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [COORD_W:0] s;
		s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		if (s[COORD_W] != s[COORD_W-1])
			return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		return s[COORD_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] abs_diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic [COORD_W:0] d;
		logic [COORD_W:0] m;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[COORD_W] ? (~d + 1'b1) : d;
		return m[COORD_W-1:0];
	endfunction

	assign wa     = AW'(in_data.atom_index);
	assign own_a  = AW'(in_q.atom_index);
	assign ra     = cmd.own_sel ? own_a : addr;
	assign ld_ok  = (in_data.atom_index < MAX_ATOMS);
	assign own_ok = (in_q.atom_index < MAX_ATOMS);
	assign rd_ok  = cmd.own_sel ? own_ok : 1'b1;
	assign n      = (cnt_q > MAX_ATOMS) ? CNT_W'(MAX_ATOMS) : cnt_q;
	assign owner_act = ({1'b0, in_q.atom_index} < n);
	assign fail   = err_q | (sum_q == '0);

	assign sts.n         = n;
	assign sts.owner_act = owner_act;
	assign sts.r_zero    = (r_q == '0);
	assign sts.ge        = ge_q;
	assign sts.fail      = fail;

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.mul_sel)
			MUL_SQX: begin
				op_a = {1'b0, dx_q};
				op_b = {1'b0, dx_q};
			end
			MUL_SQY: begin
				op_a = {1'b0, dy_q};
				op_b = {1'b0, dy_q};
			end
			MUL_SQZ: begin
				op_a = {1'b0, dz_q};
				op_b = {1'b0, dz_q};
			end
			MUL_M2: begin
				op_a = {2'b0, mu_q};
				op_b = {2'b0, mu_q};
			end
			MUL_S: begin
				op_a = {1'b0, Q_THREE - {1'b0, m2_q}};
				op_b = {2'b0, mu_q};
			end
			MUL_CI: begin
				op_a = {2'b0, ci_q};
				op_b = {2'b0, fm_q};
			end
			MUL_CJ: begin
				op_a = {2'b0, cr_q};
				op_b = {2'b0, fp_q};
			end
			MUL_WB: begin
				op_a = {9'b0, in_q.raw_weight[23:0]};
				op_b = {2'b0, q_q};
			end
			MUL_WA: begin
				op_a = {9'b0, in_q.raw_weight[47:24]};
				op_b = {2'b0, q_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_c = op_a * op_b;

	// Square root step: bring down two radicand bits, try 4*root+1.
	assign srem_n = {srem_q[REM_W-3:0], rad_q[ACC_W-1 -: 2]};
	assign strial = {1'b0, root_q, 2'b01};

	assign di_m_dr = {1'b0, di_q} - {1'b0, dr_q};
	assign dr_m_di = {1'b0, dr_q} - {1'b0, di_q};
	assign mag_c   = (di_q < dr_q) ? dr_m_di[DIST_W-1:0] : di_m_dr[DIST_W-1:0];

	assign dge    = (drem_q >= {1'b0, den_q});
	assign drem_n = dge ? (drem_q - {1'b0, den_q}) : drem_q;

	assign smag = prod_q[31 +: Q_W];
	assign fm_t = neg_q ? ({1'b0, Q_ONE} + {1'b0, smag}) : ({1'b0, Q_ONE} - {1'b0, smag});
	assign fm_c = fm_t[Q_W:1];

	assign full_c = {prod_q[WB_W-1:0], 24'b0} + {24'b0, wb_q};

	always_comb begin
		unique case (cmd.cell_src)
			CW_INIT: cell_wd = Q_ONE;
			CW_I:    cell_wd = ci_q;
			CW_J:    cell_wd = prod_q[FRAC +: Q_W];
			default: cell_wd = Q_ONE;
		endcase
	end

	// Memories: written and read one address per cycle.
	always_ff @(posedge clk) begin
		if (cmd.tbl_wr && ld_ok) begin
			mem_x[wa] <= in_data.pos_x;
			mem_y[wa] <= in_data.pos_y;
			mem_z[wa] <= in_data.pos_z;
		end
		if (cmd.tbl_rd) begin
			rd_x_q <= (rd_ok && vld_q[ra]) ? mem_x[ra] : '0;
			rd_y_q <= (rd_ok && vld_q[ra]) ? mem_y[ra] : '0;
			rd_z_q <= (rd_ok && vld_q[ra]) ? mem_z[ra] : '0;
		end
		if (cmd.dist_wr)
			dist_mem[addr] <= root_q;
		if (cmd.dist_rd)
			dr_q <= dist_mem[addr];
		if (cmd.cell_wr)
			cell_mem[addr] <= cell_wd;
		if (cmd.cell_rd)
			cr_q <= cell_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cnt_q <= CNT_W'(1);
		end else begin
			if (cmd.tbl_wr && ld_ok)
				vld_q[wa] <= 1'b1;
			if (cfg_wr)
				cnt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_ld)
			in_q <= in_data;
		if (cmd.abs_ld) begin
			ax_q <= sat_add(in_q.pos_x, rd_x_q);
			ay_q <= sat_add(in_q.pos_y, rd_y_q);
			az_q <= sat_add(in_q.pos_z, rd_z_q);
		end
		if (cmd.ai_ld) begin
			aix_q <= rd_x_q;
			aiy_q <= rd_y_q;
			aiz_q <= rd_z_q;
		end
		if (cmd.diff_pt) begin
			dx_q <= abs_diff(ax_q, rd_x_q);
			dy_q <= abs_diff(ay_q, rd_y_q);
			dz_q <= abs_diff(az_q, rd_z_q);
		end else if (cmd.diff_pr) begin
			dx_q <= abs_diff(aix_q, rd_x_q);
			dy_q <= abs_diff(aiy_q, rd_y_q);
			dz_q <= abs_diff(aiz_q, rd_z_q);
		end
		if (cmd.mul_sel != MUL_NONE)
			prod_q <= prod_c;
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (cmd.acc_add)
			acc_q <= acc_q + prod_q;
		if (cmd.sqrt_ld) begin
			rad_q  <= acc_q;
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[ACC_W-3:0], 2'b00};
			if (srem_n >= strial) begin
				srem_q <= srem_n - strial;
				root_q <= {root_q[DIST_W-2:0], 1'b1};
			end else begin
				srem_q <= srem_n;
				root_q <= {root_q[DIST_W-2:0], 1'b0};
			end
		end
		if (cmd.di_ld)
			di_q <= dr_q;
		if (cmd.r_ld) begin
			r_q   <= root_q;
			mag_q <= mag_c;
			neg_q <= (di_q < dr_q);
			ge_q  <= (mag_c >= root_q);
		end
		if (cmd.div_ld_mu) begin
			drem_q <= DIV_W'(mag_q);
			den_q  <= SUM_W'(r_q);
			quo_q  <= '0;
		end else if (cmd.div_ld_q) begin
			drem_q <= DIV_W'(cr_q);
			den_q  <= sum_q;
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			drem_q <= {drem_n[DIV_W-2:0], 1'b0};
			quo_q  <= {quo_q[Q_W-2:0], dge};
		end
		if (cmd.mu_ld)
			mu_q <= ge_q ? Q_ONE : quo_q;
		if (cmd.m2_ld)
			m2_q <= prod_q[FRAC +: Q_W];
		if (cmd.s_ld) begin
			fm_q <= fm_c;
			fp_q <= Q_ONE - fm_c;
		end
		if (cmd.ci_ld)
			ci_q <= cr_q;
		else if (cmd.ci_upd)
			ci_q <= prod_q[FRAC +: Q_W];
		if (cmd.err_clr)
			err_q <= 1'b0;
		else if (cmd.err_set)
			err_q <= 1'b1;
		if (cmd.sum_clr)
			sum_q <= '0;
		else if (cmd.sum_add)
			sum_q <= sum_q + SUM_W'(cr_q);
		if (cmd.q_ld)
			q_q <= quo_q;
		if (cmd.wb_ld)
			wb_q <= prod_q[WB_W-1:0];
		if (cmd.wt_ld)
			w_q <= full_c[FRAC +: WEIGHT_W];
		if (cmd.res_ld) begin
			out_q.abs_x       <= ax_q;
			out_q.abs_y       <= ay_q;
			out_q.abs_z       <= az_q;
			out_q.error_flag  <= fail;
			out_q.part_weight <= (fail || !owner_act) ? '0 : w_q;
		end
	end

	assign out_data = out_q;

endmodule

/* rtl/bpw_ctrl.sv */
// Controller state machine: sequences distances, atom pairs, sum and
// final division through the datapath. Depends on bpw_pkg and the macro header.
`include "becke_partition_weight_top_macros.svh"

module bpw_ctrl #(
	parameter int MAX_ATOMS = bpw_pkg::DEFAULT_MAX_ATOMS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_opcode,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  bpw_pkg::sts_t                sts,
	output bpw_pkg::cmd_t                cmd,
	output logic [$clog2(MAX_ATOMS)-1:0] addr
);
	import bpw_pkg::*;

	localparam int AW = $clog2(MAX_ATOMS);

	localparam logic [5:0] S_IDLE   = 6'd0;
	localparam logic [5:0] S_OWN_RD = 6'd1;
	localparam logic [5:0] S_ABS    = 6'd2;
	localparam logic [5:0] S_D_RD   = 6'd3;
	localparam logic [5:0] S_D_DIFF = 6'd4;
	localparam logic [5:0] S_SQX    = 6'd5;
	localparam logic [5:0] S_SQY    = 6'd6;
	localparam logic [5:0] S_SQZ    = 6'd7;
	localparam logic [5:0] S_ACC    = 6'd8;
	localparam logic [5:0] S_SQ0    = 6'd9;
	localparam logic [5:0] S_SQRT   = 6'd10;
	localparam logic [5:0] S_D_WR   = 6'd11;
	localparam logic [5:0] S_P_I    = 6'd12;
	localparam logic [5:0] S_P_I2   = 6'd13;
	localparam logic [5:0] S_P_J    = 6'd14;
	localparam logic [5:0] S_P_DIFF = 6'd15;
	localparam logic [5:0] S_P_R    = 6'd16;
	localparam logic [5:0] S_P_CHK  = 6'd17;
	localparam logic [5:0] S_DIV    = 6'd18;
	localparam logic [5:0] S_MU     = 6'd19;
	localparam logic [5:0] S_M2M    = 6'd20;
	localparam logic [5:0] S_M2L    = 6'd21;
	localparam logic [5:0] S_SM     = 6'd22;
	localparam logic [5:0] S_SL     = 6'd23;
	localparam logic [5:0] S_CI     = 6'd24;
	localparam logic [5:0] S_CJ     = 6'd25;
	localparam logic [5:0] S_CW     = 6'd26;
	localparam logic [5:0] S_NEXT   = 6'd27;
	localparam logic [5:0] S_P_IW   = 6'd28;
	localparam logic [5:0] S_SUM0   = 6'd29;
	localparam logic [5:0] S_S_RD   = 6'd30;
	localparam logic [5:0] S_S_ADD  = 6'd31;
	localparam logic [5:0] S_OWN    = 6'd32;
	localparam logic [5:0] S_OWN2   = 6'd33;
	localparam logic [5:0] S_Q      = 6'd34;
	localparam logic [5:0] S_WB     = 6'd35;
	localparam logic [5:0] S_WA     = 6'd36;
	localparam logic [5:0] S_WT     = 6'd37;
	localparam logic [5:0] S_FIN    = 6'd38;

	localparam logic [1:0] PH_DIST = 2'd0;
	localparam logic [1:0] PH_PAIR = 2'd1;
	localparam logic [1:0] PH_Q    = 2'd2;

	logic [5:0]       state_q, state_d;
	logic [1:0]       ph_q, ph_d;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d;
	logic [5:0]       k_q, k_d;
	logic             out_valid_q, out_valid_d;
	logic             accept;
	logic [CNT_W:0]   i_inc, j_inc, n_ext;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign i_inc     = {1'b0, i_q} + (CNT_W+1)'(1);
	assign j_inc     = {1'b0, j_q} + (CNT_W+1)'(1);
	assign n_ext     = {1'b0, sts.n};

	always_comb begin
		cmd         = '0;
		addr        = AW'(i_q);
		state_d     = state_q;
		ph_d        = ph_q;
		i_d         = i_q;
		j_d         = j_q;
		k_d         = k_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd.tbl_wr  = accept && (in_opcode == OP_LOAD);
		cmd.in_ld   = accept && (in_opcode == OP_POINT);
		unique case (state_q)
			S_IDLE: begin
				if (accept && (in_opcode == OP_POINT))
					state_d = S_OWN_RD;
			end
			S_OWN_RD: begin
				cmd.tbl_rd  = 1'b1;
				cmd.own_sel = 1'b1;
				state_d     = S_ABS;
			end
			S_ABS: begin
				cmd.abs_ld  = 1'b1;
				cmd.err_clr = 1'b1;
				i_d         = '0;
				ph_d        = PH_DIST;
				state_d     = (sts.n == '0) ? S_SUM0 : S_D_RD;
			end
			S_D_RD: begin
				cmd.tbl_rd   = 1'b1;
				cmd.cell_wr  = 1'b1;
				cmd.cell_src = CW_INIT;
				state_d      = S_D_DIFF;
			end
			S_D_DIFF: begin
				cmd.diff_pt = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d     = S_SQX;
			end
			S_SQX: begin
				cmd.mul_sel = MUL_SQX;
				state_d     = S_SQY;
			end
			S_SQY: begin
				cmd.mul_sel = MUL_SQY;
				cmd.acc_add = 1'b1;
				state_d     = S_SQZ;
			end
			S_SQZ: begin
				cmd.mul_sel = MUL_SQZ;
				cmd.acc_add = 1'b1;
				state_d     = S_ACC;
			end
			S_ACC: begin
				cmd.acc_add = 1'b1;
				state_d     = S_SQ0;
			end
			S_SQ0: begin
				cmd.sqrt_ld = 1'b1;
				k_d         = '0;
				state_d     = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				k_d           = k_q + 6'd1;
				if (k_q == 6'(SQRT_STEPS - 1))
					state_d = (ph_q == PH_DIST) ? S_D_WR : S_P_R;
			end
			S_D_WR: begin
				cmd.dist_wr = 1'b1;
				if (i_inc == n_ext) begin
					i_d     = CNT_W'(1);
					ph_d    = PH_PAIR;
					state_d = (sts.n == CNT_W'(1)) ? S_SUM0 : S_P_I;
				end else begin
					i_d     = i_inc[CNT_W-1:0];
					state_d = S_D_RD;
				end
			end
			S_P_I: begin
				cmd.tbl_rd  = 1'b1;
				cmd.dist_rd = 1'b1;
				cmd.cell_rd = 1'b1;
				state_d     = S_P_I2;
			end
			S_P_I2: begin
				cmd.ai_ld = 1'b1;
				cmd.di_ld = 1'b1;
				cmd.ci_ld = 1'b1;
				j_d       = '0;
				state_d   = S_P_J;
			end
			S_P_J: begin
				addr        = AW'(j_q);
				cmd.tbl_rd  = 1'b1;
				cmd.dist_rd = 1'b1;
				cmd.cell_rd = 1'b1;
				state_d     = S_P_DIFF;
			end
			S_P_DIFF: begin
				cmd.diff_pr = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d     = S_SQX;
			end
			S_P_R: begin
				cmd.r_ld = 1'b1;
				state_d  = S_P_CHK;
			end
			S_P_CHK: begin
				priority if (sts.r_zero) begin
					cmd.err_set = 1'b1;
					state_d     = S_NEXT;
				end else if (sts.ge) begin
					state_d = S_MU;
				end else begin
					cmd.div_ld_mu = 1'b1;
					k_d           = '0;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				k_d          = k_q + 6'd1;
				if (k_q == 6'(DIV_STEPS - 1))
					state_d = (ph_q == PH_Q) ? S_Q : S_MU;
			end
			S_MU: begin
				cmd.mu_ld = 1'b1;
				state_d   = S_M2M;
			end
			S_M2M: begin
				cmd.mul_sel = MUL_M2;
				state_d     = S_M2L;
			end
			S_M2L: begin
				cmd.m2_ld = 1'b1;
				state_d   = S_SM;
			end
			S_SM: begin
				cmd.mul_sel = MUL_S;
				state_d     = S_SL;
			end
			S_SL: begin
				cmd.s_ld = 1'b1;
				state_d  = S_CI;
			end
			S_CI: begin
				cmd.mul_sel = MUL_CI;
				state_d     = S_CJ;
			end
			S_CJ: begin
				cmd.mul_sel = MUL_CJ;
				cmd.ci_upd  = 1'b1;
				state_d     = S_CW;
			end
			S_CW: begin
				addr         = AW'(j_q);
				cmd.cell_wr  = 1'b1;
				cmd.cell_src = CW_J;
				state_d      = S_NEXT;
			end
			S_NEXT: begin
				if (j_inc == {1'b0, i_q}) begin
					state_d = S_P_IW;
				end else begin
					j_d     = j_inc[CNT_W-1:0];
					state_d = S_P_J;
				end
			end
			S_P_IW: begin
				cmd.cell_wr  = 1'b1;
				cmd.cell_src = CW_I;
				if (i_inc == n_ext) begin
					state_d = S_SUM0;
				end else begin
					i_d     = i_inc[CNT_W-1:0];
					state_d = S_P_I;
				end
			end
			S_SUM0: begin
				cmd.sum_clr = 1'b1;
				i_d         = '0;
				state_d     = (sts.n == '0) ? S_OWN : S_S_RD;
			end
			S_S_RD: begin
				cmd.cell_rd = 1'b1;
				state_d     = S_S_ADD;
			end
			S_S_ADD: begin
				cmd.sum_add = 1'b1;
				if (i_inc == n_ext) begin
					state_d = S_OWN;
				end else begin
					i_d     = i_inc[CNT_W-1:0];
					state_d = S_S_RD;
				end
			end
			S_OWN: begin
				if (sts.fail || !sts.owner_act) begin
					state_d = S_FIN;
				end else begin
					cmd.cell_rd = 1'b1;
					cmd.own_sel = 1'b1;
					state_d     = S_OWN2;
				end
			end
			S_OWN2: begin
				cmd.div_ld_q = 1'b1;
				k_d          = '0;
				ph_d         = PH_Q;
				state_d      = S_DIV;
			end
			S_Q: begin
				cmd.q_ld = 1'b1;
				state_d  = S_WB;
			end
			S_WB: begin
				cmd.mul_sel = MUL_WB;
				state_d     = S_WA;
			end
			S_WA: begin
				cmd.mul_sel = MUL_WA;
				cmd.wb_ld   = 1'b1;
				state_d     = S_WT;
			end
			S_WT: begin
				cmd.wt_ld = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_ld  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_DIST;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ph_q        <= ph_d;
			i_q         <= i_d;
			j_q         <= j_d;
			k_q         <= k_d;
			out_valid_q <= out_valid_d;
		end
	end

	`BPW_IMPL(a_sqrt_count, state_q == S_SQRT, k_q < 6'(SQRT_STEPS), "sqrt step count overrun")
	`BPW_IMPL(a_pair_order, state_q == S_P_J, j_q < i_q, "pair loop reached j >= i")
	`BPW_IMPL(a_out_source, $rose(out_valid_q), $past(state_q) == S_FIN, "result raised outside FIN")
	`BPW_NEXT(a_fin_load, (state_q == S_FIN) && (!out_valid_q || out_ready), out_valid_q && (state_q == S_IDLE), "result not presented after FIN")

endmodule

/* rtl/becke_partition_weight_top.sv */
// One point is in work at a time; the next item is accepted once its result has been registered
// and the controller is back in idle, while load items are accepted back to back. A flagged point
// or one whose owner is not active skips the owner division and weight scaling.
// Reset (arst_n low, asynchronous) empties the atom table, sets atom_count to 1, drops out_valid.
// Top level: valid/ready item channels, configuration write channel, controller plus datapath.
// Depends on bpw_pkg, bpw_ctrl and bpw_dp.
module becke_partition_weight_top #(
	parameter int MAX_ATOMS = bpw_pkg::DEFAULT_MAX_ATOMS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bpw_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bpw_pkg::out_t             out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bpw_pkg::CNT_W-1:0] cfg_data
);
	import bpw_pkg::*;

	cmd_t                         cmd;
	sts_t                         sts;
	logic [$clog2(MAX_ATOMS)-1:0] addr;

	// The atom_count register can always take a write; the user must write it only while the block
	// is idle, so no item is affected mid-flight; the block itself does not enforce this.
	assign cfg_ready = 1'b1;

	// The controller owns all loop counters and sequencing. A load item is
	// written into the atom table on the very edge it is accepted; a point
	// item is latched and then walked through three phases: the distance from
	// the point to every active atom, the pairwise cell products, and the sum
	// with the final owner division and weight scaling.
	// A finished result waits in the output register while the next item is
	// accepted; a second result holds in the last state until the first is taken.
	bpw_ctrl #(
		.MAX_ATOMS (MAX_ATOMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_opcode (in_data.opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd),
		.addr      (addr)
	);

	// The datapath holds the atom tables with per-entry valid bits, one shared
	// multiplier, a binary digit-by-digit square root and a restoring divider that each
	// produce one result bit per cycle, and the output register.
	bpw_dp #(
		.MAX_ATOMS (MAX_ATOMS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.addr     (addr),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
